FILE: hdl/stfg_pkg.sv
// ----------------------------------------------------------------------------
// stfg_pkg: shared types and constants of the scrolling text frame generator
// Holds the beat structs, action codes, register indexes and field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package stfg_pkg;

  localparam int NumSlotsDef   = 3;
  localparam int MaxCharsDef   = 128;
  localparam int WindowColsDef = 32;

  localparam int GlyphW     = 8;
  localparam int Rows       = 8;
  localparam int MaskW      = 32;
  localparam int LenW       = 7;
  localparam int PosW       = 11;
  localparam int ActW       = 3;
  localparam int SlotFieldW = 2;
  localparam int CidxW      = 7;
  localparam int GlyphRowsW = 64;
  localparam int LevelW     = 8;
  localparam int BrightW    = 9;
  localparam int RowW       = 3;
  localparam int ApbAddrW   = 4;
  localparam int ApbDataW   = 32;

  localparam logic [PosW-1:0]    PosNone    = '1;
  localparam logic [BrightW-1:0] BrightFull = 9'd256;

  localparam logic [ActW-1:0] ActLoad = 3'd0;
  localparam logic [ActW-1:0] ActLen  = 3'd1;
  localparam logic [ActW-1:0] ActPlay = 3'd2;
  localparam logic [ActW-1:0] ActTick = 3'd3;
  localparam logic [ActW-1:0] ActStop = 3'd4;

  localparam logic [1:0] RegRed    = 2'd0;
  localparam logic [1:0] RegGreen  = 2'd1;
  localparam logic [1:0] RegBlue   = 2'd2;
  localparam logic [1:0] RegBright = 2'd3;

  typedef struct packed {
    logic [ActW-1:0]       action;
    logic [SlotFieldW-1:0] slot;
    logic [CidxW-1:0]      char_index;
    logic [GlyphRowsW-1:0] glyph_rows;
    logic [LenW-1:0]       char_count;
  } in_beat_t;

  typedef struct packed {
    logic [RowW-1:0]   row;
    logic [MaskW-1:0]  lit_mask;
    logic [LevelW-1:0] red_out;
    logic [LevelW-1:0] green_out;
    logic [LevelW-1:0] blue_out;
    logic              last;
  } out_beat_t;

endpackage

`default_nettype wire

FILE: hdl/stfg_glyph_ram.sv
// ----------------------------------------------------------------------------
// stfg_glyph_ram: glyph store
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stfg_glyph_ram #(
  parameter int Depth = 384,
  parameter int AddrW = 9,
  parameter int DataW = 64
) (
  input  wire logic             clk_i,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [DataW-1:0] wr_data_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

FILE: hdl/scrolling_text_frame_generator.sv
// ----------------------------------------------------------------------------
// scrolling_text_frame_generator: scrolling text marquee for an 8-row matrix
// Stores glyphs per text slot, scrolls the selected slot one column per tick
// and emits eight row beats with lit mask and brightness-scaled colour.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-----------------------------
//   in       | in  | in_valid_i/in_ready_o  | in_beat_i  (in_beat_t)
//   out      | out | out_valid_o/out_ready_i| out_beat_o (out_beat_t)
//   config   | in  | psel/penable/pwrite    | paddr, pwdata, prdata
//
// load, set length and play are handled without leaving the idle state.
// tick: after acceptance, the shared subtract/compare unit reduces the start
// column into range (repeating while it is out of range, as after the length
// shrinks), then each window column takes a glyph ram read and a capture,
// then 8 output beats follow.
// stop: 8 blank output beats follow. in_ready_o is low until the last beat
// is loaded into the output register; output stalls hold the sequencer.
// reset clears control state and registers but the row masks; the glyph ram is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module scrolling_text_frame_generator #(
  parameter int NUM_SLOTS      = stfg_pkg::NumSlotsDef,
  parameter int MAX_CHARS      = stfg_pkg::MaxCharsDef,
  parameter int WINDOW_COLUMNS = stfg_pkg::WindowColsDef
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire stfg_pkg::in_beat_t               in_beat_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output stfg_pkg::out_beat_t                   out_beat_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [stfg_pkg::ApbAddrW-1:0]    paddr,
  input  wire logic [stfg_pkg::ApbDataW-1:0]    pwdata,
  output logic      [stfg_pkg::ApbDataW-1:0]    prdata,
  output logic                                  pready
);

  import stfg_pkg::*;

  localparam int NCol     = (WINDOW_COLUMNS < MaskW) ? WINDOW_COLUMNS : MaskW;
  localparam int ColW     = $clog2(NCol);
  localparam int ChW      = $clog2(MAX_CHARS);
  localparam int SlotW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RamDepth = NUM_SLOTS * (2 ** ChW);
  localparam int RamAw    = SlotW + ChW;
  localparam int ChSelW   = PosW - 3;
  localparam int ProdW    = LevelW + BrightW;

  typedef enum logic [2:0] {
    StIdle,
    StMod,
    StRead,
    StCapture,
    StEmit
  } state_e;

  state_e              state_q;
  logic                running_q;
  logic                blank_q;
  logic [SlotW-1:0]    shown_slot_q;
  logic [PosW-1:0]     pos_q;
  logic [PosW-1:0]     period_q;
  logic [PosW-1:0]     col_q;
  logic [LenW-1:0]     len_q;
  logic [ColW-1:0]     colidx_q;
  logic [RowW-1:0]     row_q;
  logic [LenW-1:0]     lens_q [NUM_SLOTS];
  logic [LevelW-1:0]   red_q;
  logic [LevelW-1:0]   green_q;
  logic [LevelW-1:0]   blue_q;
  logic [BrightW-1:0]  bright_q;
  logic                out_valid_q;
  out_beat_t           out_q;
  logic [MaskW-1:0]    mask_q [Rows];

  logic                accept;
  logic                cfg_wr;
  logic                out_load;
  logic                slot_ok;
  logic                cidx_ok;
  logic [SlotW-1:0]    slot_sel;
  logic [LenW-1:0]     len_sat;
  logic [LenW-1:0]     tick_len;
  logic [PosW-1:0]     unit_a;
  logic                unit_ge;
  logic [PosW-1:0]     unit_y;
  logic [ChSelW-1:0]   col_ch;
  logic                ch_ok;
  logic [2:0]          col_off;
  logic                ram_we;
  logic [RamAw-1:0]    ram_waddr;
  logic [RamAw-1:0]    ram_raddr;
  logic [GlyphRowsW-1:0] ram_rdata;
  logic [ProdW-1:0]    prod_r;
  logic [ProdW-1:0]    prod_g;
  logic [ProdW-1:0]    prod_b;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_wr      = psel && penable && pwrite;
  assign pready      = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign out_load    = (state_q == StEmit) && (!out_valid_q || out_ready_i);

  assign slot_ok  = 32'(in_beat_i.slot) < NUM_SLOTS;
  assign cidx_ok  = 32'(in_beat_i.char_index) < MAX_CHARS;
  assign slot_sel = SlotW'(in_beat_i.slot);
  assign len_sat  = (32'(in_beat_i.char_count) > MAX_CHARS - 1) ?
                    LenW'(MAX_CHARS - 1) : in_beat_i.char_count;
  assign tick_len = lens_q[shown_slot_q];

  // shared subtract/compare unit: start column reduction and column wrap
  assign unit_a  = (state_q == StMod) ? pos_q : col_q + PosW'(1);
  assign unit_ge = unit_a >= period_q;
  assign unit_y  = unit_ge ? unit_a - period_q : unit_a;

  assign col_ch  = col_q[PosW-1:3];
  assign col_off = col_q[2:0];
  assign ch_ok   = col_ch < {1'b0, len_q};

  assign ram_we    = accept && (in_beat_i.action == ActLoad) && slot_ok && cidx_ok;
  assign ram_waddr = {slot_sel, ChW'(in_beat_i.char_index)};
  assign ram_raddr = {shown_slot_q, ChW'(col_ch)};

  stfg_glyph_ram #(
    .Depth (RamDepth),
    .AddrW (RamAw),
    .DataW (GlyphRowsW)
  ) u_glyph_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (in_beat_i.glyph_rows),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign prod_r = ProdW'(red_q) * ProdW'(bright_q);
  assign prod_g = ProdW'(green_q) * ProdW'(bright_q);
  assign prod_b = ProdW'(blue_q) * ProdW'(bright_q);

  always_comb begin
    case (paddr[3:2])
      RegRed:    prdata = ApbDataW'(red_q);
      RegGreen:  prdata = ApbDataW'(green_q);
      RegBlue:   prdata = ApbDataW'(blue_q);
      RegBright: prdata = ApbDataW'(bright_q);
      default:   prdata = '0;
    endcase
  end

  // row masks, one column of all eight rows per capture
  always_ff @(posedge clk_i) begin
    if (accept && (in_beat_i.action == ActTick)) begin
      for (int r = 0; r < Rows; r++) begin
        mask_q[r] <= '0;
      end
    end else if (state_q == StCapture) begin
      for (int r = 0; r < Rows; r++) begin
        mask_q[r][colidx_q] <= ch_ok && ram_rdata[r*GlyphW +: GlyphW][col_off];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      running_q    <= 1'b0;
      blank_q      <= 1'b0;
      shown_slot_q <= '0;
      pos_q        <= PosNone;
      period_q     <= '0;
      col_q        <= '0;
      len_q        <= '0;
      colidx_q     <= '0;
      row_q        <= '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        lens_q[s] <= '0;
      end
      red_q        <= '0;
      green_q      <= '0;
      blue_q       <= '0;
      bright_q     <= BrightFull;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_wr) begin
        case (paddr[3:2])
          RegRed:   red_q   <= pwdata[LevelW-1:0];
          RegGreen: green_q <= pwdata[LevelW-1:0];
          RegBlue:  blue_q  <= pwdata[LevelW-1:0];
          RegBright: begin
            if (pwdata[BrightW-1:0] <= BrightFull) begin
              bright_q <= pwdata[BrightW-1:0];
            end
          end
          default: ;
        endcase
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            case (in_beat_i.action)
              ActLen: begin
                if (slot_ok) begin
                  lens_q[slot_sel] <= len_sat;
                end
              end
              ActPlay: begin
                if (slot_ok) begin
                  shown_slot_q <= slot_sel;
                  pos_q        <= PosNone;
                  bright_q     <= BrightFull;
                  running_q    <= 1'b1;
                end
              end
              ActTick: begin
                if (running_q) begin
                  period_q <= {({1'b0, tick_len} + 8'd1), 3'b000};
                  len_q    <= tick_len;
                  blank_q  <= 1'b0;
                  colidx_q <= '0;
                  if (pos_q == PosNone) begin
                    pos_q   <= '0;
                    col_q   <= '0;
                    state_q <= StRead;
                  end else begin
                    pos_q   <= pos_q + PosW'(1);
                    state_q <= StMod;
                  end
                end
              end
              ActStop: begin
                running_q <= 1'b0;
                blank_q   <= 1'b1;
                row_q     <= '0;
                state_q   <= StEmit;
              end
              default: ;
            endcase
          end
        end

        StMod: begin
          pos_q <= unit_y;
          if (!unit_ge) begin
            col_q   <= pos_q;
            state_q <= StRead;
          end
        end

        StRead: begin
          state_q <= StCapture;
        end

        StCapture: begin
          col_q <= unit_y;
          if (colidx_q == ColW'(NCol - 1)) begin
            row_q   <= '0;
            state_q <= StEmit;
          end else begin
            colidx_q <= colidx_q + ColW'(1);
            state_q  <= StRead;
          end
        end

        StEmit: begin
          if (out_load) begin
            out_q.row       <= row_q;
            out_q.lit_mask  <= blank_q ? '0 : mask_q[row_q];
            out_q.red_out   <= blank_q ? '0 : prod_r[8 +: LevelW];
            out_q.green_out <= blank_q ? '0 : prod_g[8 +: LevelW];
            out_q.blue_out  <= blank_q ? '0 : prod_b[8 +: LevelW];
            out_q.last      <= (row_q == RowW'(Rows - 1));
            if (row_q == RowW'(Rows - 1)) begin
              state_q <= StIdle;
            end else begin
              row_q <= row_q + RowW'(1);
            end
          end
        end

        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: verif/scrolling_text_frame_generator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scrolling_text_frame_generator_tb: self-checking bench for the text marquee
// A directed table walks the corner cases first: halted ticks, stops,
// ignored slots, length changes while scrolling and unused action codes.
// Random phases follow, each under new colour and brightness settings. Every
// accepted input beat runs through a local marquee predictor, and each output
// row beat is compared field by field with the oldest expected row.
// ----------------------------------------------------------------------------

module scrolling_text_frame_generator_tb;

  import stfg_pkg::*;

  localparam logic [ActW-1:0]       ActSpareLo = 3'd5;
  localparam logic [ActW-1:0]       ActSpareHi = 3'd7;
  localparam logic [SlotFieldW-1:0] BadSlot    = 2'd3;

  localparam int DirRows    = 26;
  localparam int PhaseItems = 89;
  localparam int NumPhases  = 5;
  localparam int IdleCycles = 300;
  localparam int HoldCycles = 400;

  typedef enum logic [1:0] {CheckModel, CheckQuiet, CheckBlank} row_check_e;

  typedef struct {
    logic [ActW-1:0]       act;
    logic [SlotFieldW-1:0] slot;
    logic [CidxW-1:0]      cidx;
    logic [GlyphRowsW-1:0] glyph;
    logic [LenW-1:0]       tlen;
    row_check_e            check;
  } stim_row_t;

  stim_row_t dir_tbl [DirRows] = '{
    '{ActStop,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckBlank},
    '{ActTick,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckQuiet},
    '{ActLoad,    BadSlot, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   CheckQuiet},
    '{ActLen,     BadSlot, 7'd0,   64'h0,                   7'd5,   CheckQuiet},
    '{ActPlay,    BadSlot, 7'd0,   64'h0,                   7'd0,   CheckQuiet},
    '{ActTick,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckQuiet},
    '{ActLoad,    2'd0,    7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 7'd0,   CheckQuiet},
    '{ActLoad,    2'd0,    7'd1,   64'h0,                   7'd0,   CheckQuiet},
    '{ActLoad,    2'd0,    7'd2,   64'h8040_2010_0804_0201, 7'd0,   CheckQuiet},
    '{ActLoad,    2'd0,    7'd3,   64'hAA55_AA55_AA55_AA55, 7'd0,   CheckQuiet},
    '{ActLen,     2'd0,    7'd0,   64'h0,                   7'd4,   CheckQuiet},
    '{ActPlay,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckQuiet},
    '{ActTick,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckModel},
    '{ActTick,    2'd1,    7'd9,   64'h0,                   7'd3,   CheckModel},
    '{ActLen,     2'd0,    7'd0,   64'h0,                   7'd0,   CheckQuiet},
    '{ActTick,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckModel},
    '{ActLen,     2'd0,    7'd0,   64'h0,                   7'd4,   CheckQuiet},
    '{ActTick,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckModel},
    '{ActStop,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckBlank},
    '{ActStop,    2'd2,    7'd0,   64'h0,                   7'd0,   CheckBlank},
    '{ActTick,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckQuiet},
    '{ActLoad,    2'd2,    7'd127, 64'h0123_4567_89AB_CDEF, 7'd0,   CheckQuiet},
    '{ActLen,     2'd2,    7'd0,   64'h0,                   7'd127, CheckQuiet},
    '{ActSpareLo, 2'd0,    7'd0,   64'h0,                   7'd0,   CheckQuiet},
    '{ActSpareHi, BadSlot, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF, 7'd127, CheckQuiet},
    '{ActPlay,    2'd0,    7'd0,   64'h0,                   7'd0,   CheckQuiet}
  };

  logic                   clk_i;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  in_beat_t               in_beat_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  out_beat_t              out_beat_o;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [ApbAddrW-1:0]    paddr       = '0;
  logic [ApbDataW-1:0]    pwdata      = '0;
  logic [ApbDataW-1:0]    prdata;
  logic                   pready;

  // marquee state as the predictor sees it
  logic [GlyphRowsW-1:0]  glyph_mem [NumSlotsDef][MaxCharsDef];
  bit                     glyph_set [NumSlotsDef][MaxCharsDef];
  int unsigned            slot_len  [NumSlotsDef];
  int unsigned            scroll_pos = PosNone;
  int unsigned            shown;
  bit                     running;
  int unsigned            red_lvl, green_lvl, blue_lvl;
  int unsigned            bright = BrightFull;

  out_beat_t              rows_due [$];
  out_beat_t              row_want;
  int                     mismatches;
  int                     hold_left;
  bit                     calm;

  scrolling_text_frame_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic marquee_step(input in_beat_t b, input bit emit);
    int unsigned n, period, col, ch;
    logic [7:0]  row_byte;
    out_beat_t   o;
    case (b.action)
      ActLoad: begin
        if (b.slot < NumSlotsDef) begin
          glyph_mem[b.slot][b.char_index] = b.glyph_rows;
          glyph_set[b.slot][b.char_index] = 1'b1;
        end
      end
      ActLen: begin
        if (b.slot < NumSlotsDef)
          slot_len[b.slot] = (b.char_count > MaxCharsDef - 1) ?
                             MaxCharsDef - 1 : b.char_count;
      end
      ActPlay: begin
        if (b.slot < NumSlotsDef) begin
          shown      = b.slot;
          scroll_pos = PosNone;
          bright     = BrightFull;
          running    = 1'b1;
        end
      end
      ActTick: begin
        if (running) begin
          n          = slot_len[shown];
          period     = (n + 1) * GlyphW;
          scroll_pos = (scroll_pos == PosNone) ? 0 : (scroll_pos + 1) % period;
          for (int k = 0; k < Rows; k++) begin
            o.row       = RowW'(k);
            o.lit_mask  = '0;
            o.red_out   = LevelW'((red_lvl * bright) >> 8);
            o.green_out = LevelW'((green_lvl * bright) >> 8);
            o.blue_out  = LevelW'((blue_lvl * bright) >> 8);
            o.last      = (k == Rows - 1);
            for (int j = 0; j < WindowColsDef; j++) begin
              col      = (scroll_pos + j) % period;
              ch       = col / GlyphW;
              row_byte = (ch < n) ? glyph_mem[shown][ch][8*k +: 8] : 8'h00;
              o.lit_mask[j] = row_byte[col % GlyphW];
            end
            if (emit) rows_due.push_back(o);
          end
        end
      end
      ActStop: begin
        running = 1'b0;
        for (int k = 0; k < Rows; k++) begin
          o      = '0;
          o.row  = RowW'(k);
          o.last = (k == Rows - 1);
          if (emit) rows_due.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  // first glyph of the scrolling text that was never loaded, or -1
  function automatic int first_unloaded();
    if (!running) return -1;
    for (int c = 0; c < slot_len[shown]; c++)
      if (!glyph_set[shown][c]) return c;
    return -1;
  endfunction

  function automatic logic [SlotFieldW-1:0] pick_slot();
    if ($urandom_range(0, 9) == 0) return BadSlot;
    return SlotFieldW'($urandom_range(0, NumSlotsDef - 1));
  endfunction

  task automatic pick_item(output in_beat_t b);
    int unsigned dice;
    int          hole;
    b.action      = ActTick;
    b.slot        = SlotFieldW'($urandom);
    b.char_index  = CidxW'($urandom);
    b.glyph_rows  = {$urandom, $urandom};
    b.char_count  = LenW'($urandom);
    dice = $urandom_range(0, 99);
    if (dice < 55) begin
      // fill the shown text before scrolling over it
      hole = first_unloaded();
      if (hole >= 0) begin
        b.action     = ActLoad;
        b.slot       = SlotFieldW'(shown);
        b.char_index = CidxW'(hole);
      end
    end else if (dice < 70) begin
      b.action = ActLoad;
      b.slot   = pick_slot();
      if ($urandom_range(0, 3) != 0) b.char_index = CidxW'($urandom_range(0, 15));
      if ($urandom_range(0, 7) == 0) b.glyph_rows = '0;
      else if ($urandom_range(0, 7) == 0) b.glyph_rows = '1;
    end else if (dice < 79) begin
      b.action = ActLen;
      b.slot   = pick_slot();
      dice = $urandom_range(0, 99);
      if (dice < 80) b.char_count = LenW'($urandom_range(0, 8));
      else if (dice < 96) b.char_count = LenW'($urandom_range(9, 24));
      else b.char_count = LenW'(MaxCharsDef - 1);
    end else if (dice < 85) begin
      b.action = ActPlay;
      b.slot   = pick_slot();
    end else if (dice < 91) begin
      b.action = ActStop;
    end else begin
      b.action = ActW'($urandom_range(ActSpareLo, ActSpareHi));
    end
  endtask

  task automatic sender_gap();
    if (!calm) begin
      while ($urandom_range(0, 99) < 30) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic send_beat(input in_beat_t b, input bit emit);
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    marquee_step(b, emit);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegRed:    red_lvl   = data[7:0];
      RegGreen:  green_lvl = data[7:0];
      RegBlue:   blue_lvl  = data[7:0];
      RegBright: if (data[8:0] <= BrightFull) bright = data[8:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (rows_due.size() != 0) @(posedge clk_i);
    repeat (IdleCycles) @(posedge clk_i);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rows_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected row beat, expected none actual %0h", $time, out_beat_o);
      end else begin
        row_want = rows_due.pop_front();
        cmp_field("row", row_want.row, out_beat_o.row);
        cmp_field("lit_mask", row_want.lit_mask, out_beat_o.lit_mask);
        cmp_field("red_out", row_want.red_out, out_beat_o.red_out);
        cmp_field("green_out", row_want.green_out, out_beat_o.green_out);
        cmp_field("blue_out", row_want.blue_out, out_beat_o.blue_out);
        cmp_field("last", row_want.last, out_beat_o.last);
      end
    end
  end

  initial begin
    in_beat_t b;
    out_beat_t blank;
    int sent;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(RegRed, 32'h0000_00FF);
    cfg_write(RegGreen, 32'h0000_0080);
    cfg_write(RegBlue, 32'h0000_0001);
    cfg_write(RegBright, {23'd0, BrightFull});

    for (int i = 0; i < DirRows; i++) begin
      b = '{dir_tbl[i].act, dir_tbl[i].slot, dir_tbl[i].cidx, dir_tbl[i].glyph,
            dir_tbl[i].tlen};
      sender_gap();
      send_beat(b, dir_tbl[i].check == CheckModel);
      if (dir_tbl[i].check == CheckBlank) begin
        for (int k = 0; k < Rows; k++) begin
          blank      = '0;
          blank.row  = RowW'(k);
          blank.last = (k == Rows - 1);
          rows_due.push_back(blank);
        end
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      calm = (p == 0);
      cfg_write(RegRed, {24'($urandom), (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom)});
      cfg_write(RegGreen, {24'($urandom), (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom)});
      cfg_write(RegBlue, {24'($urandom), (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom)});
      case (p)
        0: cfg_write(RegBright, {23'($urandom), BrightFull});
        1: cfg_write(RegBright, {23'($urandom), 9'd0});
        2: cfg_write(RegBright, {23'($urandom), 9'd128});
        3: begin
          cfg_write(RegBright, {23'($urandom), 9'd257});
          cfg_write(RegBright, {23'($urandom), 9'd1});
        end
        default: begin
          cfg_write(RegBright, {23'($urandom), 9'h1FF});
          cfg_write(RegBright, {23'($urandom), 9'($urandom_range(0, BrightFull))});
        end
      endcase
      // receiver backs off while the sender keeps pushing
      if (p == 2) hold_left = HoldCycles;
      sent = 0;
      while (sent < PhaseItems) begin
        pick_item(b);
        sender_gap();
        send_beat(b, 1'b1);
        sent++;
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/stfg_pkg.sv
hdl/stfg_glyph_ram.sv
hdl/scrolling_text_frame_generator.sv
verif/scrolling_text_frame_generator_tb.sv
